FILE: rtl/rlt_pkg.sv
`timescale 1ns / 1ps

package rlt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int COUNT_WIDTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int PTR_W       = IDX_W + 1;
    localparam int REF_W       = 16;
    localparam int KEY_W       = 32;

    localparam logic [1:0] FUNC_SEARCH  = 2'd0;
    localparam logic [1:0] FUNC_ADD     = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_REL_ALL = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_SAT       = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] cls;
        logic [KEY_W-1:0] typ;
        logic [KEY_W-1:0] obj;
        logic [KEY_W-1:0] ext;
    } key_t;

    typedef struct packed {
        key_t                   key;
        logic [COUNT_WIDTH-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [REF_W-1:0] ref_count;
        logic             unlocked;
        key_t             key;
        logic             last;
    } result_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic logic [REF_W-1:0] count_to_ref(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH+REF_W-1:0] ext;
        ext = {{REF_W{1'b0}}, c};
        return ext[REF_W-1:0];
    endfunction

endpackage

FILE: rtl/rlt_ram.sv
`timescale 1ns / 1ps

module rlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/refcount_lock_table_top.sv
`timescale 1ns / 1ps

// Channel  Handshake              Payload
// req      req_valid/req_ready    func, lock_class, lock_type, object_id, extra_id
// rsp      rsp_valid/rsp_ready    status, found, ref_count, unlocked,
//                                 out_class, out_type, out_object, out_extra, last
//
// One item at a time; req_ready is high only while idle.
// Search/add/release: pipelined scan of the entry RAM, one entry per cycle,
// stopping on a hit.
// Release-all: walks every slot and frees each held entry, one response per entry.
// A stalled rsp holds the output register; the next item can still be taken.
// Reset empties the table through valid flops; no clearing pass.
module refcount_lock_table_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_ready,
    input  logic [1:0]  func,
    input  logic [31:0] lock_class,
    input  logic [31:0] lock_type,
    input  logic [31:0] object_id,
    input  logic [31:0] extra_id,
    output logic        rsp_valid,
    input  logic        rsp_ready,
    output logic [1:0]  status,
    output logic        found,
    output logic [15:0] ref_count,
    output logic        unlocked,
    output logic [31:0] out_class,
    output logic [31:0] out_type,
    output logic [31:0] out_object,
    output logic [31:0] out_extra,
    output logic        last
);

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_SCAN    = 3'd1;
    localparam logic [2:0] S_DECIDE  = 3'd2;
    localparam logic [2:0] S_RA_RD   = 3'd3;
    localparam logic [2:0] S_RA_DATA = 3'd4;
    localparam logic [2:0] S_FIN     = 3'd5;

    logic [2:0] state_reg, state_next;
    logic [rlt_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [rlt_pkg::PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic cmp_vld_reg, cmp_vld_next;
    logic [rlt_pkg::IDX_W-1:0] cmp_idx_reg, cmp_idx_next;
    logic free_found_reg, free_found_next;
    logic [rlt_pkg::IDX_W-1:0] free_idx_reg, free_idx_next;
    logic hit_reg, hit_next;
    logic [rlt_pkg::IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [rlt_pkg::COUNT_WIDTH-1:0] hit_cnt_reg, hit_cnt_next;
    logic [1:0] func_reg, func_next;
    rlt_pkg::key_t key_reg, key_next;
    rlt_pkg::result_t pend_reg, pend_next;
    logic pend_vld_reg, pend_vld_next;
    rlt_pkg::result_t out_reg, out_next;
    logic out_valid_reg, out_valid_next;

    logic ram_we;
    logic [rlt_pkg::IDX_W-1:0] ram_waddr;
    rlt_pkg::entry_t ram_wdata;
    logic ram_re;
    logic [rlt_pkg::IDX_W-1:0] ram_raddr;
    rlt_pkg::entry_t ram_rdata;

    logic out_free;
    logic cmp_hit;
    logic rd_in_range;
    logic [rlt_pkg::IDX_W-1:0] rd_idx;
    logic [rlt_pkg::COUNT_WIDTH-1:0] cnt_inc;
    logic [rlt_pkg::COUNT_WIDTH-1:0] cnt_dec;

    rlt_ram #(
        .WIDTH (rlt_pkg::ENTRY_W),
        .DEPTH (rlt_pkg::TABLE_DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign req_ready   = (state_reg == S_IDLE);
    assign out_free    = !out_valid_reg || rsp_ready;
    assign rd_in_range = (rd_ptr_reg < rlt_pkg::PTR_W'(rlt_pkg::TABLE_DEPTH));
    assign rd_idx      = rd_ptr_reg[rlt_pkg::IDX_W-1:0];
    assign cmp_hit     = cmp_vld_reg && valid_reg[cmp_idx_reg] && (ram_rdata.key == key_reg);
    assign cnt_inc     = hit_cnt_reg + rlt_pkg::COUNT_WIDTH'(1);
    assign cnt_dec     = hit_cnt_reg - rlt_pkg::COUNT_WIDTH'(1);

    always_comb
    begin
        state_next      = state_reg;
        valid_next      = valid_reg;
        rd_ptr_next     = rd_ptr_reg;
        cmp_vld_next    = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_cnt_next    = hit_cnt_reg;
        func_next       = func_reg;
        key_next        = key_reg;
        pend_next       = pend_reg;
        pend_vld_next   = pend_vld_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg && !rsp_ready;
        ram_we          = 1'b0;
        ram_waddr       = hit_idx_reg;
        ram_wdata       = '0;
        ram_re          = 1'b0;
        ram_raddr       = rd_idx;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    func_next       = func;
                    key_next        = '{cls: lock_class, typ: lock_type,
                                        obj: object_id, ext: extra_id};
                    rd_ptr_next     = '0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    pend_vld_next   = 1'b0;
                    state_next      = (func == rlt_pkg::FUNC_REL_ALL) ? S_RA_RD : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (rd_in_range)
                begin
                    ram_re       = 1'b1;
                    rd_ptr_next  = rd_ptr_reg + rlt_pkg::PTR_W'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_idx;
                    if (!free_found_reg && !valid_reg[rd_idx])
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx;
                    end
                end
                if (cmp_hit)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_cnt_next = ram_rdata.count;
                    state_next   = S_DECIDE;
                end
                else if (cmp_vld_reg &&
                         cmp_idx_reg == rlt_pkg::IDX_W'(rlt_pkg::TABLE_DEPTH - 1))
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                pend_next = '{status: rlt_pkg::ST_OK, found: hit_reg, ref_count: '0,
                              unlocked: 1'b0, key: key_reg, last: 1'b1};
                ram_wdata.key = key_reg;
                unique case (func_reg)
                    rlt_pkg::FUNC_SEARCH:
                    begin
                        if (hit_reg)
                        begin
                            pend_next.ref_count = rlt_pkg::count_to_ref(hit_cnt_reg);
                        end
                    end
                    rlt_pkg::FUNC_ADD:
                    begin
                        if (hit_reg)
                        begin
                            if (hit_cnt_reg == '1)
                            begin
                                pend_next.status    = rlt_pkg::ST_SAT;
                                pend_next.ref_count = rlt_pkg::count_to_ref(hit_cnt_reg);
                            end
                            else
                            begin
                                ram_we              = 1'b1;
                                ram_wdata.count     = cnt_inc;
                                pend_next.ref_count = rlt_pkg::count_to_ref(cnt_inc);
                            end
                        end
                        else if (free_found_reg)
                        begin
                            ram_we                   = 1'b1;
                            ram_waddr                = free_idx_reg;
                            ram_wdata.count          = rlt_pkg::COUNT_WIDTH'(1);
                            valid_next[free_idx_reg] = 1'b1;
                            pend_next.ref_count      = rlt_pkg::REF_W'(1);
                        end
                        else
                        begin
                            pend_next.status = rlt_pkg::ST_FULL;
                        end
                    end
                    rlt_pkg::FUNC_RELEASE:
                    begin
                        if (!hit_reg)
                        begin
                            pend_next.status = rlt_pkg::ST_NOT_FOUND;
                        end
                        else if (hit_cnt_reg <= rlt_pkg::COUNT_WIDTH'(1))
                        begin
                            valid_next[hit_idx_reg] = 1'b0;
                            pend_next.unlocked      = 1'b1;
                        end
                        else
                        begin
                            ram_we              = 1'b1;
                            ram_wdata.count     = cnt_dec;
                            pend_next.ref_count = rlt_pkg::count_to_ref(cnt_dec);
                        end
                    end
                    rlt_pkg::FUNC_REL_ALL:
                    begin
                        // handled by the release-all states
                        pend_next.last = 1'b1;
                    end
                endcase
                state_next = S_FIN;
            end
            S_RA_RD:
            begin
                if (rd_in_range)
                begin
                    if (valid_reg[rd_idx])
                    begin
                        ram_re       = 1'b1;
                        cmp_idx_next = rd_idx;
                        state_next   = S_RA_DATA;
                    end
                    else
                    begin
                        rd_ptr_next = rd_ptr_reg + rlt_pkg::PTR_W'(1);
                    end
                end
                else
                begin
                    if (pend_vld_reg)
                    begin
                        pend_next.last = 1'b1;
                    end
                    else
                    begin
                        pend_next      = '0;
                        pend_next.last = 1'b1;
                    end
                    state_next = S_FIN;
                end
            end
            S_RA_DATA:
            begin
                if (!pend_vld_reg || out_free)
                begin
                    if (pend_vld_reg)
                    begin
                        out_next       = pend_reg;
                        out_valid_next = 1'b1;
                    end
                    pend_next = '{status: rlt_pkg::ST_OK, found: 1'b1,
                                  ref_count: rlt_pkg::count_to_ref(ram_rdata.count),
                                  unlocked: 1'b1, key: ram_rdata.key, last: 1'b0};
                    pend_vld_next           = 1'b1;
                    valid_next[cmp_idx_reg] = 1'b0;
                    rd_ptr_next             = rd_ptr_reg + rlt_pkg::PTR_W'(1);
                    state_next              = S_RA_RD;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_next       = pend_reg;
                    out_valid_next = 1'b1;
                    pend_vld_next  = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            valid_reg      <= '0;
            cmp_vld_reg    <= 1'b0;
            free_found_reg <= 1'b0;
            hit_reg        <= 1'b0;
            pend_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            rd_ptr_reg     <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            cmp_vld_reg    <= cmp_vld_next;
            free_found_reg <= free_found_next;
            hit_reg        <= hit_next;
            pend_vld_reg   <= pend_vld_next;
            out_valid_reg  <= out_valid_next;
            rd_ptr_reg     <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg  <= cmp_idx_next;
        free_idx_reg <= free_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_cnt_reg  <= hit_cnt_next;
        func_reg     <= func_next;
        key_reg      <= key_next;
        pend_reg     <= pend_next;
        out_reg      <= out_next;
    end

    assign rsp_valid  = out_valid_reg;
    assign status     = out_reg.status;
    assign found      = out_reg.found;
    assign ref_count  = out_reg.ref_count;
    assign unlocked   = out_reg.unlocked;
    assign out_class  = out_reg.key.cls;
    assign out_type   = out_reg.key.typ;
    assign out_object = out_reg.key.obj;
    assign out_extra  = out_reg.key.ext;
    assign last       = out_reg.last;

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

    a_write_only_decide: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_DECIDE))
        else $error("entry RAM written outside decide step");

    a_release_all_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && func_reg == rlt_pkg::FUNC_REL_ALL) |-> (valid_reg == '0))
        else $error("release-all left entries held");

    a_fin_pushes: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_free) |=> (rsp_valid && state_reg == S_IDLE))
        else $error("final item not loaded into output register");

endmodule
